// ===== rtl/core/sag_pkg.sv =====
// sag_pkg: shared types and constants for the session access guard.
// Holds the time width, operation and result codes, and the state,
// configuration and item structs. No dependencies.
`timescale 1ns / 1ps

package sag_pkg;

  // Width of event and state time values, counted in seconds.
  localparam int TIME_W = 32;
  // Saturating counters (rate window and failed logins).
  localparam int CNT_W = 8;

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam cnt_t CNT_MAX = '1;

  typedef enum logic [2:0] {
    OP_REGISTER = 3'd0,
    OP_LOGIN    = 3'd1,
    OP_WHOAMI   = 3'd2,
    OP_LOGOUT   = 3'd3,
    OP_UNKNOWN  = 3'd4,
    OP_EMPTY    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_ADDED  = 2'd0,
    ST_EXISTS = 2'd1,
    ST_FAILED = 2'd2
  } store_t;

  typedef enum logic [4:0] {
    K_RATE_LIMITED  = 5'd0,
    K_EMPTY         = 5'd1,
    K_REG_USAGE     = 5'd2,
    K_BAD_NAME      = 5'd3,
    K_SHORT_PASS    = 5'd4,
    K_REGISTERED    = 5'd5,
    K_EXISTS        = 5'd6,
    K_STORE_FAIL    = 5'd7,
    K_LOGIN_USAGE   = 5'd8,
    K_LOCKED        = 5'd9,
    K_LOGIN_OK      = 5'd10,
    K_LOCKED_NOW    = 5'd11,
    K_BAD_CREDS     = 5'd12,
    K_AUTH_REQUIRED = 5'd13,
    K_WHOAMI_OK     = 5'd14,
    K_NOT_LOGGED_IN = 5'd15,
    K_LOGGED_OUT    = 5'd16,
    K_UNKNOWN       = 5'd17
  } kind_t;

  typedef enum logic [2:0] {
    CFG_RATE_MAX    = 3'd0,
    CFG_RATE_WINDOW = 3'd1,
    CFG_FAIL_LIMIT  = 3'd2,
    CFG_LOCKOUT     = 3'd3,
    CFG_SESS_TMO    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]  rate_max;
    logic [15:0] rate_window;
    logic [7:0]  fail_limit;
    logic [15:0] lockout;
    logic [15:0] sess_tmo;
  } cfg_t;

  typedef struct packed {
    logic  session_on;
    time_t last_act;
    cnt_t  win_cnt;
    time_t win_start;   // zero: no window open yet
    cnt_t  fail_cnt;
    time_t lock_end;    // zero: not locked
  } state_t;

  typedef struct packed {
    logic [2:0] op;
    time_t      now;
    logic       args_complete;
    logic       name_ok;
    logic       pass_long_enough;
    logic [1:0] store_outcome;
    logic       credentials_ok;
  } item_t;

endpackage

// ===== rtl/core/sag_policy.sv =====
// sag_policy: combinational decision logic for one command event.
// Computes the result kind and the next session state from the current
// state, configuration and event. Depends on sag_pkg.
`timescale 1ns / 1ps

module sag_policy (
  input  sag_pkg::item_t  item,
  input  sag_pkg::state_t st,
  input  sag_pkg::cfg_t   cfg,
  output sag_pkg::state_t nxt,
  output sag_pkg::kind_t  kind
);

  function automatic sag_pkg::time_t elapsed(sag_pkg::time_t now_v, sag_pkg::time_t then_v);
    return (now_v >= then_v) ? (now_v - then_v) : '0;
  endfunction

  function automatic sag_pkg::cnt_t sat_inc(sag_pkg::cnt_t c);
    return (c == sag_pkg::CNT_MAX) ? sag_pkg::CNT_MAX : c + sag_pkg::cnt_t'(1);
  endfunction

  sag_pkg::time_t          win_el;
  sag_pkg::time_t          sess_el;
  logic                    new_win;
  sag_pkg::cnt_t           cnt_inc;
  logic                    admit;
  logic                    lock_set;
  logic                    lock_live;
  logic                    lock_expired;
  sag_pkg::cnt_t           fail_inc;
  logic [sag_pkg::TIME_W:0] lock_sum;
  sag_pkg::time_t          lock_new;

  always_comb begin
    win_el  = elapsed(item.now, st.win_start);
    sess_el = elapsed(item.now, st.last_act);
    new_win = (st.win_start == '0) ||
              (win_el > sag_pkg::TIME_W'(cfg.rate_window));
    cnt_inc = sat_inc(st.win_cnt);
    // first request of a window is always let through
    admit   = new_win || (cnt_inc <= cfg.rate_max);

    lock_set     = (st.lock_end != '0);
    lock_live    = lock_set && (item.now < st.lock_end);
    lock_expired = lock_set && !(item.now < st.lock_end);
    fail_inc     = sat_inc(lock_expired ? '0 : st.fail_cnt);

    // lockout end saturates at the largest time value
    lock_sum = {1'b0, item.now} + (sag_pkg::TIME_W + 1)'(cfg.lockout);
    lock_new = lock_sum[sag_pkg::TIME_W] ? '1 : lock_sum[sag_pkg::TIME_W-1:0];
  end

  always_comb begin
    nxt  = st;
    kind = sag_pkg::K_UNKNOWN;

    // rejected requests count against the window as well
    if (new_win) begin
      nxt.win_start = item.now;
      nxt.win_cnt   = sag_pkg::cnt_t'(1);
    end else begin
      nxt.win_cnt = cnt_inc;
    end

    if (!admit) begin
      kind = sag_pkg::K_RATE_LIMITED;
    end else begin
      unique case (item.op)
        sag_pkg::OP_REGISTER: begin
          if (!item.args_complete) begin
            kind = sag_pkg::K_REG_USAGE;
          end else if (!item.name_ok) begin
            kind = sag_pkg::K_BAD_NAME;
          end else if (!item.pass_long_enough) begin
            kind = sag_pkg::K_SHORT_PASS;
          end else if (item.store_outcome == sag_pkg::ST_ADDED) begin
            kind = sag_pkg::K_REGISTERED;
          end else if (item.store_outcome == sag_pkg::ST_EXISTS) begin
            kind = sag_pkg::K_EXISTS;
          end else begin
            kind = sag_pkg::K_STORE_FAIL;
          end
        end
        sag_pkg::OP_LOGIN: begin
          if (!item.args_complete) begin
            kind = sag_pkg::K_LOGIN_USAGE;
          end else if (lock_live) begin
            kind = sag_pkg::K_LOCKED;
          end else begin
            if (lock_expired) begin
              nxt.lock_end = '0;
              nxt.fail_cnt = '0;
            end
            if (item.credentials_ok) begin
              nxt.session_on = 1'b1;
              nxt.last_act   = item.now;
              nxt.fail_cnt   = '0;
              nxt.lock_end   = '0;
              kind           = sag_pkg::K_LOGIN_OK;
            end else begin
              nxt.fail_cnt = fail_inc;
              kind         = sag_pkg::K_BAD_CREDS;
              if (fail_inc >= cfg.fail_limit) begin
                if (lock_new != '0 && item.now < lock_new) begin
                  nxt.lock_end = lock_new;
                  kind         = sag_pkg::K_LOCKED_NOW;
                end else if (lock_new != '0) begin
                  // zero-length lockout is over at once
                  nxt.lock_end = '0;
                  nxt.fail_cnt = '0;
                end else begin
                  nxt.lock_end = '0;
                end
              end
            end
          end
        end
        sag_pkg::OP_WHOAMI: begin
          if (!st.session_on) begin
            kind = sag_pkg::K_AUTH_REQUIRED;
          end else if (sess_el > sag_pkg::TIME_W'(cfg.sess_tmo)) begin
            nxt.session_on = 1'b0;
            nxt.last_act   = '0;
            kind           = sag_pkg::K_AUTH_REQUIRED;
          end else begin
            nxt.last_act = item.now;
            kind         = sag_pkg::K_WHOAMI_OK;
          end
        end
        sag_pkg::OP_LOGOUT: begin
          if (!st.session_on) begin
            kind = sag_pkg::K_NOT_LOGGED_IN;
          end else begin
            nxt.session_on = 1'b0;
            nxt.last_act   = '0;
            kind           = sag_pkg::K_LOGGED_OUT;
          end
        end
        sag_pkg::OP_EMPTY: begin
          kind = sag_pkg::K_EMPTY;
        end
        default: begin
          kind = sag_pkg::K_UNKNOWN;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/session_access_guard.sv =====
// session_access_guard: top level of the per-connection access guard.
// Input register, sag_policy decision logic, session state and result
// register. Depends on sag_pkg and sag_policy.
`timescale 1ns / 1ps

// Usage
//   Slave stream (s_*): one command event per transaction. Master stream
//   (m_*): one result per event, in event order.
//   Config port: cfg_wen writes cfg_wdata into register cfg_idx
//   (0 rate max, 1 rate window, 2 fail limit, 3 lockout, 4 session
//   timeout). Write only while no event is in flight.
// Timing
//   An accepted event is held in the input register, decided
//   combinationally and lands in the result register, which drives
//   m_tvalid. The state update is done at the same edge as that load,
//   so the next event sees it with no bubble; while m_tready is high,
//   one event per cycle is sustained, limited by the single decision stage.
// Stall
//   While m_tready is low the result holds, and one more event may wait
//   in the input register; s_tready then drops until m_tready returns.
// Reset
//   rst (synchronous) empties both registers, clears the session, rate
//   and lockout state and loads the default configuration
//   (5 requests, 10 s window, 3 failures, 30 s lockout, 300 s timeout).
module session_access_guard (
  input  logic        clk,
  input  logic        rst,
  // [2:0] op, [34:3] now_seconds, [35] args_complete, [36] name_ok,
  // [37] pass_long_enough, [39:38] store_outcome, [40] credentials_ok
  input  logic [47:0] s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [4:0] result_kind, [5] logged_in_now
  output logic [7:0]  m_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_idx,
  input  logic [15:0] cfg_wdata
);

  logic            in_vld;
  sag_pkg::item_t  in_item;
  logic            out_vld;
  sag_pkg::kind_t  out_kind;
  logic            out_li;
  sag_pkg::state_t st;
  sag_pkg::state_t st_next;
  sag_pkg::kind_t  kind;
  sag_pkg::cfg_t   cfg;
  logic            fire;

  // decide the held event when the result register is free
  assign fire     = in_vld && (!out_vld || m_tready);
  assign s_tready = !in_vld || fire;
  assign m_tvalid = out_vld;
  assign m_tdata  = {2'b00, out_li, out_kind};

  sag_policy u_policy (
    .item (in_item),
    .st   (st),
    .cfg  (cfg),
    .nxt  (st_next),
    .kind (kind)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_vld <= 1'b1;
    end else if (fire) begin
      in_vld <= 1'b0;
    end
    if (s_tvalid && s_tready) begin
      in_item.op               <= s_tdata[2:0];
      in_item.now              <= sag_pkg::TIME_W'(s_tdata[34:3]);
      in_item.args_complete    <= s_tdata[35];
      in_item.name_ok          <= s_tdata[36];
      in_item.pass_long_enough <= s_tdata[37];
      in_item.store_outcome    <= s_tdata[39:38];
      in_item.credentials_ok   <= s_tdata[40];
    end
  end

  // session state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= '0;
      out_vld <= 1'b0;
    end else begin
      if (fire) begin
        st      <= st_next;
        out_vld <= 1'b1;
      end else if (m_tready) begin
        out_vld <= 1'b0;
      end
    end
    if (fire) begin
      out_kind <= kind;
      out_li   <= st_next.session_on;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rate_max    <= 8'd5;
      cfg.rate_window <= 16'd10;
      cfg.fail_limit  <= 8'd3;
      cfg.lockout     <= 16'd30;
      cfg.sess_tmo    <= 16'd300;
    end else if (cfg_wen) begin
      unique case (cfg_idx)
        sag_pkg::CFG_RATE_MAX:    cfg.rate_max    <= cfg_wdata[7:0];
        sag_pkg::CFG_RATE_WINDOW: cfg.rate_window <= cfg_wdata;
        sag_pkg::CFG_FAIL_LIMIT:  cfg.fail_limit  <= cfg_wdata[7:0];
        sag_pkg::CFG_LOCKOUT:     cfg.lockout     <= cfg_wdata;
        sag_pkg::CFG_SESS_TMO:    cfg.sess_tmo    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // a logged-out session never keeps an activity time
  a_idle_no_activity: assert property (@(posedge clk) disable iff (rst)
    !st.session_on |-> (st.last_act == '0))
    else $error("last activity time set while logged out");

  // an open rate window always has a nonzero count
  a_window_count: assert property (@(posedge clk) disable iff (rst)
    (st.win_start != '0) |-> (st.win_cnt != '0))
    else $error("rate window open with zero count");

  // login success leaves the session logged in
  a_login_flag: assert property (@(posedge clk) disable iff (rst)
    (out_vld && out_kind == sag_pkg::K_LOGIN_OK) |-> out_li)
    else $error("login ok reported without session");

  // results that report no session must show the flag low
  a_no_session_flag: assert property (@(posedge clk) disable iff (rst)
    (out_vld && (out_kind == sag_pkg::K_LOGGED_OUT ||
                 out_kind == sag_pkg::K_NOT_LOGGED_IN ||
                 out_kind == sag_pkg::K_AUTH_REQUIRED)) |-> !out_li)
    else $error("session flag high on a no-session result");

  // a waiting event and a stalled result close the input side
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (in_vld && out_vld && !m_tready) |-> !s_tready)
    else $error("input accepted while both stages are full");

endmodule

// ===== test/tb_session_access_guard.sv =====
// tb_session_access_guard: self-checking bench for the session access guard.
// Directed table and random phases, checked against an in-bench predictor.
// Depends on sag_pkg and session_access_guard.
`timescale 1ns / 1ps

module tb_session_access_guard;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 8;
  localparam int LONG_HOLD = 300;
  localparam int HOLD_AFTER = 720;   // mid-run, while the sender is still busy
  localparam int N_PHASES = 8;
  localparam int PHASE_ITEMS = 118;
  localparam int SATURATE_ITEMS = 300; // enough to pin the window counter
  localparam int N_SCRIPT = 25;

  // op and store encodings the package leaves unnamed
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam logic [1:0] ST_UNDEFINED = 2'd3;

  localparam sag_pkg::cfg_t RESET_REGS = '{rate_max: 8'd5, rate_window: 16'd10,
                                           fail_limit: 8'd3, lockout: 16'd30,
                                           sess_tmo: 16'd300};

  typedef struct packed {
    sag_pkg::kind_t kind;
    logic           session_on;
  } verdict_t;

  typedef struct packed {
    logic [2:0]     op;
    sag_pkg::time_t at;
    logic           args;
    logic           name_ok;
    logic           pass_ok;
    logic [1:0]     store;
    logic           cred;
    logic           typed;      // 1: expectation below is used as is
    sag_pkg::kind_t kind;
    logic           session_on;
  } script_row_t;

  // Reset config: 5 requests per 10 s window, lockout after 3 failures for 30 s.
  localparam script_row_t SCRIPT [N_SCRIPT] = '{
    // window opens at 1 s; flags on an empty event are ignored
    '{sag_pkg::OP_EMPTY,    32'd1,  1'b1, 1'b1, 1'b1, ST_UNDEFINED,      1'b1, 1'b1,
      sag_pkg::K_EMPTY, 1'b0},
    '{sag_pkg::OP_REGISTER, 32'd1,  1'b0, 1'b1, 1'b1, sag_pkg::ST_ADDED,  1'b1, 1'b1,
      sag_pkg::K_REG_USAGE, 1'b0},
    '{sag_pkg::OP_REGISTER, 32'd2,  1'b1, 1'b0, 1'b1, sag_pkg::ST_ADDED,  1'b0, 1'b1,
      sag_pkg::K_BAD_NAME, 1'b0},
    '{sag_pkg::OP_REGISTER, 32'd2,  1'b1, 1'b1, 1'b0, sag_pkg::ST_ADDED,  1'b0, 1'b1,
      sag_pkg::K_SHORT_PASS, 1'b0},
    '{sag_pkg::OP_REGISTER, 32'd3,  1'b1, 1'b1, 1'b1, sag_pkg::ST_ADDED,  1'b0, 1'b1,
      sag_pkg::K_REGISTERED, 1'b0},
    // sixth request in the window
    '{OP_SPARE7,            32'd3,  1'b1, 1'b1, 1'b1, sag_pkg::ST_ADDED,  1'b1, 1'b1,
      sag_pkg::K_RATE_LIMITED, 1'b0},
    '{sag_pkg::OP_REGISTER, 32'd20, 1'b1, 1'b1, 1'b1, sag_pkg::ST_EXISTS, 1'b0, 1'b1,
      sag_pkg::K_EXISTS, 1'b0},
    '{sag_pkg::OP_REGISTER, 32'd20, 1'b1, 1'b1, 1'b1, sag_pkg::ST_FAILED, 1'b0, 1'b1,
      sag_pkg::K_STORE_FAIL, 1'b0},
    '{sag_pkg::OP_REGISTER, 32'd21, 1'b1, 1'b1, 1'b1, ST_UNDEFINED,      1'b0, 1'b1,
      sag_pkg::K_STORE_FAIL, 1'b0},
    '{sag_pkg::OP_UNKNOWN,  32'd21, 1'b0, 1'b0, 1'b0, sag_pkg::ST_ADDED,  1'b0, 1'b1,
      sag_pkg::K_UNKNOWN, 1'b0},
    '{OP_SPARE6,            32'd22, 1'b1, 1'b1, 1'b1, ST_UNDEFINED,      1'b1, 1'b1,
      sag_pkg::K_UNKNOWN, 1'b0},
    '{sag_pkg::OP_WHOAMI,   32'd40, 1'b1, 1'b1, 1'b1, sag_pkg::ST_ADDED,  1'b1, 1'b1,
      sag_pkg::K_AUTH_REQUIRED, 1'b0},
    '{sag_pkg::OP_LOGOUT,   32'd40, 1'b1, 1'b1, 1'b1, sag_pkg::ST_ADDED,  1'b1, 1'b1,
      sag_pkg::K_NOT_LOGGED_IN, 1'b0},
    '{sag_pkg::OP_LOGIN,    32'd41, 1'b0, 1'b1, 1'b1, sag_pkg::ST_ADDED,  1'b1, 1'b1,
      sag_pkg::K_LOGIN_USAGE, 1'b0},
    '{sag_pkg::OP_LOGIN,    32'd41, 1'b1, 1'b1, 1'b1, sag_pkg::ST_ADDED,  1'b0, 1'b1,
      sag_pkg::K_BAD_CREDS, 1'b0},
    '{sag_pkg::OP_LOGIN,    32'd42, 1'b1, 1'b1, 1'b1, sag_pkg::ST_ADDED,  1'b0, 1'b1,
      sag_pkg::K_BAD_CREDS, 1'b0},
    // third failure locks until 90 s
    '{sag_pkg::OP_LOGIN,    32'd60, 1'b1, 1'b1, 1'b1, sag_pkg::ST_ADDED,  1'b0, 1'b1,
      sag_pkg::K_LOCKED_NOW, 1'b0},
    '{sag_pkg::OP_LOGIN,    32'd61, 1'b1, 1'b1, 1'b1, sag_pkg::ST_ADDED,  1'b1, 1'b1,
      sag_pkg::K_LOCKED, 1'b0},
    // lock expires exactly at its end time, then a normal session
    '{sag_pkg::OP_LOGIN,    32'd90, 1'b1, 1'b1, 1'b1, sag_pkg::ST_ADDED,  1'b1, 1'b0,
      sag_pkg::K_RATE_LIMITED, 1'b0},
    '{sag_pkg::OP_WHOAMI,   32'd95, 1'b1, 1'b1, 1'b1, sag_pkg::ST_ADDED,  1'b1, 1'b0,
      sag_pkg::K_RATE_LIMITED, 1'b0},
    '{sag_pkg::OP_LOGOUT,   32'd96, 1'b1, 1'b1, 1'b1, sag_pkg::ST_ADDED,  1'b1, 1'b0,
      sag_pkg::K_RATE_LIMITED, 1'b0},
    '{sag_pkg::OP_LOGIN,    32'd97, 1'b1, 1'b1, 1'b1, sag_pkg::ST_ADDED,  1'b1, 1'b0,
      sag_pkg::K_RATE_LIMITED, 1'b0},
    // idle past the session timeout
    '{sag_pkg::OP_WHOAMI,   32'd500, 1'b1, 1'b1, 1'b1, sag_pkg::ST_ADDED, 1'b1, 1'b0,
      sag_pkg::K_RATE_LIMITED, 1'b0},
    // clock steps back: stays in the current window
    '{sag_pkg::OP_EMPTY,    32'd499, 1'b0, 1'b0, 1'b0, sag_pkg::ST_ADDED, 1'b0, 1'b0,
      sag_pkg::K_RATE_LIMITED, 1'b0},
    '{sag_pkg::OP_LOGIN,    32'd499, 1'b1, 1'b0, 1'b0, sag_pkg::ST_ADDED, 1'b1, 1'b0,
      sag_pkg::K_RATE_LIMITED, 1'b0}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic [47:0]       s_tdata = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        m_tdata;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic              cfg_wen = 1'b0;
  sag_pkg::cfg_idx_t cfg_idx = sag_pkg::CFG_RATE_MAX;
  logic [15:0]       cfg_wdata = '0;

  // predicted guard state and register copy
  sag_pkg::state_t mirror = '0;
  sag_pkg::cfg_t   mirror_regs = RESET_REGS;

  verdict_t    owed[$];
  int          mismatches = 0;
  int          events_sent = 0;
  int          results_checked = 0;
  int          cycle_count = 0;
  logic [31:0] kinds_seen = '0;
  bit          idle_on = 1'b1;
  bit          hold_done = 1'b0;

  session_access_guard dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_wen   (cfg_wen),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic sag_pkg::time_t since(sag_pkg::time_t now, sag_pkg::time_t then);
    return (now >= then) ? now - then : '0;
  endfunction

  function automatic sag_pkg::cnt_t bump(sag_pkg::cnt_t c);
    return (c == sag_pkg::CNT_MAX) ? c : c + 8'd1;
  endfunction

  // Expired lockout clears itself along with the failure count.
  function automatic logic lockout_active(sag_pkg::time_t now);
    if (mirror.lock_end == '0) return 1'b0;
    if (now >= mirror.lock_end) begin
      mirror.lock_end = '0;
      mirror.fail_cnt = '0;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic sag_pkg::kind_t judge_event(sag_pkg::item_t ev);
    sag_pkg::time_t now;
    logic [32:0]    lock_sum;
    now = ev.now;
    // fixed window; a rejected request still counts
    if (mirror.win_start == '0 ||
        since(now, mirror.win_start) > {16'd0, mirror_regs.rate_window}) begin
      mirror.win_start = now;
      mirror.win_cnt = 8'd1;
    end else begin
      mirror.win_cnt = bump(mirror.win_cnt);
      if (mirror.win_cnt > mirror_regs.rate_max) return sag_pkg::K_RATE_LIMITED;
    end
    case (ev.op)
      sag_pkg::OP_REGISTER: begin
        if (!ev.args_complete) return sag_pkg::K_REG_USAGE;
        if (!ev.name_ok) return sag_pkg::K_BAD_NAME;
        if (!ev.pass_long_enough) return sag_pkg::K_SHORT_PASS;
        case (ev.store_outcome)
          sag_pkg::ST_ADDED:  return sag_pkg::K_REGISTERED;
          sag_pkg::ST_EXISTS: return sag_pkg::K_EXISTS;
          default:            return sag_pkg::K_STORE_FAIL;
        endcase
      end
      sag_pkg::OP_LOGIN: begin
        if (!ev.args_complete) return sag_pkg::K_LOGIN_USAGE;
        if (lockout_active(now)) return sag_pkg::K_LOCKED;
        if (ev.credentials_ok) begin
          mirror.session_on = 1'b1;
          mirror.last_act = now;
          mirror.fail_cnt = '0;
          mirror.lock_end = '0;
          return sag_pkg::K_LOGIN_OK;
        end
        mirror.fail_cnt = bump(mirror.fail_cnt);
        if (mirror.fail_cnt >= mirror_regs.fail_limit) begin
          lock_sum = {1'b0, now} + {17'd0, mirror_regs.lockout};
          mirror.lock_end = lock_sum[32] ? '1 : lock_sum[31:0];
        end
        return lockout_active(now) ? sag_pkg::K_LOCKED_NOW : sag_pkg::K_BAD_CREDS;
      end
      sag_pkg::OP_WHOAMI: begin
        if (!mirror.session_on) return sag_pkg::K_AUTH_REQUIRED;
        if (since(now, mirror.last_act) > {16'd0, mirror_regs.sess_tmo}) begin
          mirror.session_on = 1'b0;
          mirror.last_act = '0;
          return sag_pkg::K_AUTH_REQUIRED;
        end
        mirror.last_act = now;
        return sag_pkg::K_WHOAMI_OK;
      end
      sag_pkg::OP_LOGOUT: begin
        if (!mirror.session_on) return sag_pkg::K_NOT_LOGGED_IN;
        mirror.session_on = 1'b0;
        mirror.last_act = '0;
        return sag_pkg::K_LOGGED_OUT;
      end
      sag_pkg::OP_EMPTY: return sag_pkg::K_EMPTY;
      default:           return sag_pkg::K_UNKNOWN;
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus

  // Mostly small forward steps, now and then a long gap or a short step back.
  function automatic sag_pkg::time_t advance(sag_pkg::time_t t, bit big_ok);
    logic [32:0] sum;
    int unsigned r;
    int unsigned step;
    r = $urandom_range(0, 99);
    if (r < 3 && t > 32'd8) return t - $urandom_range(1, 5);
    if (r < 55) step = $urandom_range(0, 3);
    else if (r < 88) step = $urandom_range(4, 20);
    else if (r < 98 || !big_ok) step = $urandom_range(21, 400);
    else step = $urandom_range(401, 70000);
    sum = {1'b0, t} + {1'b0, step};
    return sum[32] ? '1 : sum[31:0];
  endfunction

  // Weighted toward logins and whoami so sessions and lockouts happen often.
  function automatic sag_pkg::item_t random_event(sag_pkg::time_t t);
    sag_pkg::item_t ev;
    int unsigned    r;
    logic [31:0]    rnd;
    r = $urandom_range(0, 99);
    rnd = $urandom;
    if (r < 16) ev.op = sag_pkg::OP_REGISTER;
    else if (r < 46) ev.op = sag_pkg::OP_LOGIN;
    else if (r < 70) ev.op = sag_pkg::OP_WHOAMI;
    else if (r < 82) ev.op = sag_pkg::OP_LOGOUT;
    else if (r < 88) ev.op = sag_pkg::OP_EMPTY;
    else if (r < 93) ev.op = sag_pkg::OP_UNKNOWN;
    else ev.op = rnd[2] ? OP_SPARE6 : OP_SPARE7;
    ev.now = t;
    ev.args_complete = ($urandom_range(0, 9) != 0);
    ev.name_ok = ($urandom_range(0, 4) != 0);
    ev.pass_long_enough = ($urandom_range(0, 4) != 0);
    ev.store_outcome = rnd[1:0];
    ev.credentials_ok = ($urandom_range(0, 9) < 6);
    return ev;
  endfunction

  // Low extremes, high extremes, zero request limit, random, and a
  // near-wraparound phase with the longest lockout.
  function automatic sag_pkg::cfg_t phase_config(int p);
    sag_pkg::cfg_t c;
    case (p)
      0: c = '{rate_max: 8'd1, rate_window: 16'd1, fail_limit: 8'd1, lockout: 16'd1,
               sess_tmo: 16'd1};
      1: c = '{rate_max: 8'd255, rate_window: 16'hFFFF, fail_limit: 8'd255,
               lockout: 16'hFFFF, sess_tmo: 16'hFFFF};
      2: c = '{rate_max: 8'd0, rate_window: 16'd6, fail_limit: 8'd2, lockout: 16'd20,
               sess_tmo: 16'd40};
      N_PHASES - 1: c = '{rate_max: 8'd12, rate_window: 16'd15, fail_limit: 8'd2,
                          lockout: 16'hFFFF, sess_tmo: 16'd90};
      default: begin
        c.rate_max = 8'($urandom_range(1, 8));
        c.rate_window = 16'($urandom_range(1, 20));
        c.fail_limit = 8'($urandom_range(1, 5));
        c.lockout = 16'($urandom_range(1, 60));
        c.sess_tmo = 16'($urandom_range(1, 120));
      end
    endcase
    return c;
  endfunction

  // One transaction on the slave side; the expectation is queued on acceptance.
  task automatic drive_event(input sag_pkg::item_t ev, input logic typed,
                             input verdict_t typed_v);
    verdict_t v;
    s_tdata <= {7'd0, ev.credentials_ok, ev.store_outcome, ev.pass_long_enough,
                ev.name_ok, ev.args_complete, ev.now, ev.op};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    v.kind = judge_event(ev);
    v.session_on = mirror.session_on;
    owed.push_back(typed ? typed_v : v);
    events_sent++;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Stop offering and let every outstanding result drain.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (owed.size() != 0) @(posedge clk);
  endtask

  task automatic write_config(input sag_pkg::cfg_t c);
    cfg_wen <= 1'b1;
    cfg_idx <= sag_pkg::CFG_RATE_MAX;    cfg_wdata <= {8'd0, c.rate_max};   @(posedge clk);
    cfg_idx <= sag_pkg::CFG_RATE_WINDOW; cfg_wdata <= c.rate_window;        @(posedge clk);
    cfg_idx <= sag_pkg::CFG_FAIL_LIMIT;  cfg_wdata <= {8'd0, c.fail_limit}; @(posedge clk);
    cfg_idx <= sag_pkg::CFG_LOCKOUT;     cfg_wdata <= c.lockout;            @(posedge clk);
    cfg_idx <= sag_pkg::CFG_SESS_TMO;    cfg_wdata <= c.sess_tmo;           @(posedge clk);
    cfg_wen <= 1'b0;
    mirror_regs = c;
  endtask

  initial begin
    sag_pkg::item_t ev;
    sag_pkg::time_t now_t;
    int             i;
    int             p;
    int             k;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < N_SCRIPT; i++) begin
      ev.op = SCRIPT[i].op;
      ev.now = SCRIPT[i].at;
      ev.args_complete = SCRIPT[i].args;
      ev.name_ok = SCRIPT[i].name_ok;
      ev.pass_long_enough = SCRIPT[i].pass_ok;
      ev.store_outcome = SCRIPT[i].store;
      ev.credentials_ok = SCRIPT[i].cred;
      drive_event(ev, SCRIPT[i].typed,
                  verdict_t'{kind: SCRIPT[i].kind, session_on: SCRIPT[i].session_on});
    end
    now_t = SCRIPT[N_SCRIPT-1].at;

    for (p = 0; p < N_PHASES; p++) begin
      settle();
      write_config(phase_config(p));
      idle_on = (p != 3) && (p != N_PHASES - 1);
      // later phases move the clock into the upper half and near wraparound
      if (p == N_PHASES - 2) now_t = 32'h8000_0000 + $urandom_range(0, 32'h7F00_0000);
      if (p == N_PHASES - 1) now_t = 32'hFFFF_F000;
      for (k = 0; k < ((p == 1) ? SATURATE_ITEMS : PHASE_ITEMS); k++) begin
        now_t = advance(now_t, p != N_PHASES - 1);
        drive_event(random_event(now_t), 1'b0, '0);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Drove %0d command events (%0d from the table, the rest over %0d register sets),",
             events_sent, N_SCRIPT, N_PHASES);
    $display("checked %0d results covering %0d of 18 result kinds.",
             results_checked, $countones(kinds_seen));
    if (mismatches == 0 && owed.size() == 0) begin
      $display("tb_session_access_guard OK");
    end else begin
      $display("tb_session_access_guard NOT OK");
    end
    $finish;
  end

  // ---------------------------------------------------------------- receiver

  // Random back-pressure, plus one long hold while the sender keeps offering.
  initial begin
    forever begin
      @(posedge clk);
      if (!hold_done && results_checked >= HOLD_AFTER) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        m_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compare each master-side transaction with the oldest expectation.
  always @(posedge clk) begin : check_result
    verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_checked++;
      kinds_seen[m_tdata[4:0]] = 1'b1;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 30)
          $display("%0t: unexpected result: expected none, got kind %0d logged_in_now %0b",
                   $time, m_tdata[4:0], m_tdata[5]);
      end else begin
        want = owed.pop_front();
        if (m_tdata[4:0] != want.kind) begin
          mismatches++;
          if (mismatches <= 30)
            $display("%0t: result %0d result_kind: expected %0d, got %0d",
                     $time, results_checked, want.kind, m_tdata[4:0]);
        end
        if (m_tdata[5] != want.session_on) begin
          mismatches++;
          if (mismatches <= 30)
            $display("%0t: result %0d logged_in_now: expected %0b, got %0b",
                     $time, results_checked, want.session_on, m_tdata[5]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, owed.size());
      $display("tb_session_access_guard NOT OK");
      $finish;
    end
  end

endmodule
